@@ hdl/closest_approach_collision_test_top_assert.svh @@
// ---------------------------------------------------------------------------
// assertion macros for the closest approach collision test
// clocked on clk_i, disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef CLOSEST_APPROACH_COLLISION_TEST_TOP_ASSERT_SVH
`define CLOSEST_APPROACH_COLLISION_TEST_TOP_ASSERT_SVH

// concurrent check with the default clock and reset
`define CACT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication check: when cond holds, prop holds in the same cycle
`define CACT_ASSERT_IMPL(label, cond, prop, msg) \
  `CACT_ASSERT(label, (cond) |-> (prop), msg)

`endif

@@ hdl/cact_pkg.sv @@
// ---------------------------------------------------------------------------
// cact_pkg
// shared types and constants of the closest approach collision test
// ---------------------------------------------------------------------------
package cact_pkg;

  // register indexes
  localparam logic [1:0] REG_VERT_LIMIT = 2'd0;
  localparam logic [1:0] REG_MARGIN     = 2'd1;
  localparam logic [1:0] REG_MIN_SPEED  = 2'd2;
  localparam logic [1:0] REG_HORIZON    = 2'd3;

  // register reset values
  localparam logic [15:0] VERT_LIMIT_RST = 16'd1280;
  localparam logic [15:0] MARGIN_RST     = 16'd384;
  localparam logic [31:0] MIN_SPEED_RST  = 32'd107374;
  localparam logic [7:0]  HORIZON_RST    = 8'd100;

  // decision codes
  localparam logic [2:0] DEC_VERT_GAP  = 3'd0;
  localparam logic [2:0] DEC_OVERLAP   = 3'd1;
  localparam logic [2:0] DEC_TOO_SLOW  = 3'd2;
  localparam logic [2:0] DEC_APP_IN    = 3'd3;
  localparam logic [2:0] DEC_APP_OUT   = 3'd4;

  // quotient bits of the approach time (Q.24, below 2^24)
  localparam int DIV_STEPS = 24;

  typedef struct packed {
    logic signed [24:0] dpx;
    logic signed [24:0] dpy;
    logic signed [20:0] dvx;
    logic signed [20:0] dvy;
    logic [33:0]        comb2;
    logic               done;
    logic               hit;
    logic [2:0]         code;
  } carry_t;

  typedef struct packed {
    carry_t      c;
    logic        tzero;
    logic        clamp;
    logic [41:0] rem;
    logic [41:0] den;
    logic [23:0] q;
  } div_t;

endpackage

@@ hdl/closest_approach_collision_test_top.sv @@
// ---------------------------------------------------------------------------
// closest_approach_collision_test_top
// pipelined closest point of approach test for one pair of bodies per cycle
// ---------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o with two bodies (position, horizontal
//   velocity, radius); a transfer happens when valid is high and stall low
//   output channel: out_valid_o / out_stall_i with possible_hit_o and
//   decided_by_o, one result per input transfer, in order
//   datapath: input stages, then the 24 stage restoring divider that
//   forms the approach time one bit a stage, then the output stages
//   throughput: one pair per cycle if not stalled; every stage is a register step
//   reset: all valid bits clear, configuration registers take their reset values
//   stall: when the output register holds a result and out_stall_i is high
//   the whole pipe freezes and in_stall_o rises; nothing is lost or repeated
//   configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i; write
//   only while the pipe is empty
// ---------------------------------------------------------------------------
module closest_approach_collision_test_top
  import cact_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [23:0]  pos_a_x_i,
  input  logic signed [23:0]  pos_a_y_i,
  input  logic signed [23:0]  pos_a_z_i,
  input  logic signed [23:0]  pos_b_x_i,
  input  logic signed [23:0]  pos_b_y_i,
  input  logic signed [23:0]  pos_b_z_i,
  input  logic signed [19:0]  vel_a_x_i,
  input  logic signed [19:0]  vel_a_y_i,
  input  logic signed [19:0]  vel_b_x_i,
  input  logic signed [19:0]  vel_b_y_i,
  input  logic [13:0]         radius_a_i,
  input  logic [13:0]         radius_b_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                possible_hit_o,
  output logic [2:0]          decided_by_o
);

  localparam int NSTG = 5 + DIV_STEPS + 4;

  // configuration registers
  logic [15:0] vlim_q, margin_q;
  logic [31:0] minspd_q;
  logic [7:0]  horizon_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlim_q    <= VERT_LIMIT_RST;
      margin_q  <= MARGIN_RST;
      minspd_q  <= MIN_SPEED_RST;
      horizon_q <= HORIZON_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VERT_LIMIT: vlim_q    <= cfg_data_i[15:0];
        REG_MARGIN:     margin_q  <= cfg_data_i[15:0];
        REG_MIN_SPEED:  minspd_q  <= cfg_data_i;
        REG_HORIZON:    horizon_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // global advance: the pipe moves unless a held result is stalled
  logic en;
  logic [NSTG-1:0] vld_q;

  assign en         = !vld_q[NSTG-1] || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // stage 1: differences and combined distance
  logic signed [24:0] s1_dpx_q, s1_dpy_q, s1_dpz_q;
  logic signed [20:0] s1_dvx_q, s1_dvy_q;
  logic [16:0]        s1_comb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dpx_q  <= 25'(pos_b_x_i) - 25'(pos_a_x_i);
      s1_dpy_q  <= 25'(pos_b_y_i) - 25'(pos_a_y_i);
      s1_dpz_q  <= 25'(pos_b_z_i) - 25'(pos_a_z_i);
      s1_dvx_q  <= 21'(vel_b_x_i) - 21'(vel_a_x_i);
      s1_dvy_q  <= 21'(vel_b_y_i) - 21'(vel_a_y_i);
      s1_comb_q <= {3'b0, radius_a_i} + {3'b0, radius_b_i} + {1'b0, margin_q};
    end
  end

  // stage 2: products and vertical gap test
  logic signed [49:0] s2_pxx_q, s2_pyy_q;
  logic signed [41:0] s2_vxx_q, s2_vyy_q;
  logic signed [45:0] s2_dxv_q, s2_dyv_q;
  logic [33:0]        s2_comb2_q;
  logic               s2_zfar_q;
  logic signed [24:0] s2_dpx_q, s2_dpy_q;
  logic signed [20:0] s2_dvx_q, s2_dvy_q;
  logic [24:0]        s1_zabs;

  assign s1_zabs = s1_dpz_q[24] ? 25'(-s1_dpz_q) : 25'(s1_dpz_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_pxx_q   <= s1_dpx_q * s1_dpx_q;
      s2_pyy_q   <= s1_dpy_q * s1_dpy_q;
      s2_vxx_q   <= s1_dvx_q * s1_dvx_q;
      s2_vyy_q   <= s1_dvy_q * s1_dvy_q;
      s2_dxv_q   <= 46'(s1_dpx_q) * 46'(s1_dvx_q);
      s2_dyv_q   <= 46'(s1_dpy_q) * 46'(s1_dvy_q);
      s2_comb2_q <= 34'(s1_comb_q) * 34'(s1_comb_q);
      s2_zfar_q  <= s1_zabs > {9'b0, vlim_q};
      s2_dpx_q   <= s1_dpx_q;
      s2_dpy_q   <= s1_dpy_q;
      s2_dvx_q   <= s1_dvx_q;
      s2_dvy_q   <= s1_dvy_q;
    end
  end

  // stage 3: sums and early decisions
  logic [50:0]        s2_dist2;
  logic [41:0]        s2_speed;
  logic signed [46:0] s2_dot;
  carry_t             s3_c_d, s3_c_q;
  logic [41:0]        s3_speed_q;
  logic [45:0]        s3_num_q;
  logic               s3_tzero_q;

  assign s2_dist2 = {1'b0, s2_pxx_q} + {1'b0, s2_pyy_q};
  assign s2_speed = s2_vxx_q + s2_vyy_q;
  assign s2_dot   = 47'(s2_dxv_q) + 47'(s2_dyv_q);

  always_comb begin
    s3_c_d       = '0;
    s3_c_d.dpx   = s2_dpx_q;
    s3_c_d.dpy   = s2_dpy_q;
    s3_c_d.dvx   = s2_dvx_q;
    s3_c_d.dvy   = s2_dvy_q;
    s3_c_d.comb2 = s2_comb2_q;
    s3_c_d.done  = 1'b1;
    s3_c_d.hit   = 1'b0;
    s3_c_d.code  = DEC_APP_OUT;
    if (s2_zfar_q) begin
      s3_c_d.code = DEC_VERT_GAP;
    end else if (s2_dist2 < {17'b0, s2_comb2_q}) begin
      s3_c_d.hit  = 1'b1;
      s3_c_d.code = DEC_OVERLAP;
    end else if ({22'b0, s2_speed} < {32'b0, minspd_q}) begin
      s3_c_d.code = DEC_TOO_SLOW;
    end else begin
      s3_c_d.done = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_c_q     <= s3_c_d;
      s3_speed_q <= s2_speed;
      s3_num_q   <= 46'(-s2_dot);
      s3_tzero_q <= !s2_dot[46];
    end
  end

  // stage 4: horizon times speed for the clamp test
  carry_t      s4_c_q;
  logic [49:0] s4_hs_q;
  logic [41:0] s4_speed_q;
  logic [45:0] s4_num_q;
  logic        s4_tzero_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_c_q     <= s3_c_q;
      s4_hs_q    <= 50'(horizon_q) * 50'(s3_speed_q);
      s4_speed_q <= s3_speed_q;
      s4_num_q   <= s3_num_q;
      s4_tzero_q <= s3_tzero_q;
    end
  end

  // stage 5 and divider: t = floor(num * 2^24 / speed), one bit a stage
  div_t div_q [0:DIV_STEPS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q[0].c     <= s4_c_q;
      div_q[0].tzero <= s4_tzero_q;
      div_q[0].clamp <= {s4_num_q, 8'b0} >= {4'b0, s4_hs_q};
      div_q[0].rem   <= s4_tzero_q ? '0 : s4_num_q[41:0];
      div_q[0].den   <= s4_speed_q;
      div_q[0].q     <= '0;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [42:0] r2;
    logic        ge;

    assign r2 = {div_q[k-1].rem, 1'b0};
    assign ge = r2 >= {1'b0, div_q[k-1].den};

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[k].c     <= div_q[k-1].c;
        div_q[k].tzero <= div_q[k-1].tzero;
        div_q[k].clamp <= div_q[k-1].clamp;
        div_q[k].den   <= div_q[k-1].den;
        div_q[k].rem   <= ge ? 42'(r2 - {1'b0, div_q[k-1].den}) : r2[41:0];
        div_q[k].q     <= {div_q[k-1].q[22:0], ge};
      end
    end
  end

  // m1: velocity times approach time
  div_t               dv_last;
  logic [23:0]        t_sel;
  carry_t             m1_c_q;
  logic signed [45:0] m1_prx_q, m1_pry_q;

  assign dv_last = div_q[DIV_STEPS];
  assign t_sel   = dv_last.tzero ? '0 :
                   dv_last.clamp ? {horizon_q, 16'b0} : dv_last.q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_c_q   <= dv_last.c;
      m1_prx_q <= 46'(dv_last.c.dvx) * $signed({22'b0, t_sel});
      m1_pry_q <= 46'(dv_last.c.dvy) * $signed({22'b0, t_sel});
    end
  end

  // m2: closest separation per axis, truncated magnitude
  logic signed [49:0] m1_cx, m1_cy;
  logic [49:0]        m1_mx, m1_my;
  carry_t             m2_c_q;
  logic [25:0]        m2_ax_q, m2_ay_q;
  logic               m2_far_q;

  assign m1_cx = 50'($signed({m1_c_q.dpx, 24'b0})) + 50'(m1_prx_q);
  assign m1_cy = 50'($signed({m1_c_q.dpy, 24'b0})) + 50'(m1_pry_q);
  assign m1_mx = m1_cx[49] ? 50'(-m1_cx) : 50'(m1_cx);
  assign m1_my = m1_cy[49] ? 50'(-m1_cy) : 50'(m1_cy);

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_c_q   <= m1_c_q;
      m2_ax_q  <= m1_mx[41:16];
      m2_ay_q  <= m1_my[41:16];
      m2_far_q <= (|m1_mx[49:42]) || (|m1_my[49:42]);
    end
  end

  // m3: squares
  carry_t      m3_c_q;
  logic [51:0] m3_ax2_q, m3_ay2_q;
  logic        m3_far_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m3_c_q   <= m2_c_q;
      m3_ax2_q <= 52'(m2_ax_q) * 52'(m2_ax_q);
      m3_ay2_q <= 52'(m2_ay_q) * 52'(m2_ay_q);
      m3_far_q <= m2_far_q;
    end
  end

  // output register: early decision, else final compare against combined distance squared
  logic [52:0] m3_sep2;
  logic        m3_in;
  logic        hit_q;
  logic [2:0]  code_q;

  assign m3_sep2 = {1'b0, m3_ax2_q} + {1'b0, m3_ay2_q};
  assign m3_in   = !m3_far_q && (m3_sep2 < {3'b0, m3_c_q.comb2, 16'b0});

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (m3_c_q.done) begin
        hit_q  <= m3_c_q.hit;
        code_q <= m3_c_q.code;
      end else begin
        hit_q  <= m3_in;
        code_q <= m3_in ? DEC_APP_IN : DEC_APP_OUT;
      end
    end
  end

  assign out_valid_o    = vld_q[NSTG-1];
  assign possible_hit_o = hit_q;
  assign decided_by_o   = code_q;

endmodule

@@ hdl/cact_checker.sv @@
// ---------------------------------------------------------------------------
// cact_assert_checker
// port level checks of the closest approach collision test
// ---------------------------------------------------------------------------
`include "closest_approach_collision_test_top_assert.svh"

module cact_assert_checker
  import cact_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       possible_hit_o,
  input logic [2:0] decided_by_o
);

  // a stalled result stays
  `CACT_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped in stall")

  // input only stalls behind a stalled result
  `CACT_ASSERT_IMPL(a_stall_src, in_stall_o, out_valid_o && out_stall_i, "stall without cause")

  // hit flag matches the deciding rule
  `CACT_ASSERT_IMPL(a_hit_code, out_valid_o,
    possible_hit_o == (decided_by_o == DEC_OVERLAP || decided_by_o == DEC_APP_IN),
    "hit flag disagrees with rule")

  // rule code within range
  `CACT_ASSERT_IMPL(a_code_rng, out_valid_o, decided_by_o <= DEC_APP_OUT, "bad rule code")

endmodule

bind closest_approach_collision_test_top cact_assert_checker u_cact_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .possible_hit_o (possible_hit_o),
  .decided_by_o   (decided_by_o)
);
